/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker of the zigzag/spiral reorder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/zz2s_pkg.sv */
// Types, constants and helper functions of the zigzag-to-spiral address generator.
// No dependencies.
`default_nettype none

package zz2s_pkg;

  localparam int GS_W        = 7;
  localparam int MAX_SIDE_DF = 64;
  localparam logic [GS_W-1:0] GRID_RESET = GS_W'(8);

  typedef enum logic [1:0] {
    SP_RIGHT = 2'd0,
    SP_DOWN  = 2'd1,
    SP_LEFT  = 2'd2,
    SP_UP    = 2'd3
  } sp_dir_e;

  typedef struct packed {
    logic step;
    logic restart;
    logic reload;
  } scan_ctrl_t;

  // Largest coordinate for a grid_size value, clamped to 1..max_side.
  function automatic logic [GS_W-1:0] side_edge(input logic [GS_W-1:0] gs,
                                                input int unsigned max_side);
    int unsigned n;
    n = 32'(gs);
    if (n == 0) begin
      n = 1;
    end else if (n > max_side) begin
      n = max_side;
    end
    return GS_W'(n - 1);
  endfunction

endpackage

`default_nettype wire

/* sv/zz2s_scan.sv */
// Scan state of the zigzag source walk and the clockwise spiral destination walk.
// Depends on zz2s_pkg.
`default_nettype none

module zz2s_scan
  import zz2s_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DF,
  parameter int CW = 6,
  parameter int SW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scan_ctrl_t    ctrl_i,
  input  wire logic [CW-1:0] edge_i,
  input  wire logic [SW-1:0] last_idx_i,
  output logic      [CW-1:0] src_row_o,
  output logic      [CW-1:0] src_col_o,
  output logic      [CW-1:0] dst_row_o,
  output logic      [CW-1:0] dst_col_o,
  output logic               last_o
);

  logic [CW-1:0] zr_q, zc_q, sr_q, sc_q, bt_q, bb_q, bl_q, br_q;
  logic [CW-1:0] zr_d, zc_d, sr_d, sc_d, bt_d, bb_d, bl_d, br_d;
  logic [CW-1:0] zr, zc, sr, sc, bt, bb, bl, br;
  sp_dir_e       dir_q, dir_d, dir;
  logic [SW-1:0] cnt_q, cnt_d, cnt;
  logic          done_q, done_d, done;
  logic          is_last, adv;
  logic [CW-1:0] zr_a, zc_a, sr_a, sc_a, bt_a, bb_a, bl_a, br_a;
  sp_dir_e       dir_a;

  // state as seen by this transaction (restart applied)
  always_comb begin
    if (ctrl_i.restart) begin
      zr = '0; zc = '0; sr = '0; sc = '0;
      bt = '0; bl = '0; bb = edge_i; br = edge_i;
      dir = SP_RIGHT; cnt = '0; done = 1'b0;
    end else begin
      zr = zr_q; zc = zc_q; sr = sr_q; sc = sc_q;
      bt = bt_q; bl = bl_q; bb = bb_q; br = br_q;
      dir = dir_q; cnt = cnt_q; done = done_q;
    end
  end

  assign is_last   = !done && (cnt >= last_idx_i);
  assign adv       = !done && !is_last;
  assign src_row_o = zr;
  assign src_col_o = zc;
  assign dst_row_o = sr;
  assign dst_col_o = sc;
  assign last_o    = is_last;

  // zigzag: even anti-diagonal moves up-right, odd moves down-left
  always_comb begin
    zr_a = zr;
    zc_a = zc;
    if ((zr[0] ^ zc[0]) == 1'b0) begin
      if (zc == edge_i) begin
        zr_a = CW'(zr + 1'b1);
      end else if (zr == '0) begin
        zc_a = CW'(zc + 1'b1);
      end else begin
        zr_a = CW'(zr - 1'b1);
        zc_a = CW'(zc + 1'b1);
      end
    end else begin
      if (zr == edge_i) begin
        zc_a = CW'(zc + 1'b1);
      end else if (zc == '0) begin
        zr_a = CW'(zr + 1'b1);
      end else begin
        zr_a = CW'(zr + 1'b1);
        zc_a = CW'(zc - 1'b1);
      end
    end
  end

  // spiral: walk inside shrinking layer bounds
  always_comb begin
    sr_a = sr; sc_a = sc; dir_a = dir;
    bt_a = bt; bb_a = bb; bl_a = bl; br_a = br;
    unique case (dir)
      SP_RIGHT: begin
        if (sc < br) begin
          sc_a = CW'(sc + 1'b1);
        end else begin
          bt_a = CW'(bt + 1'b1); dir_a = SP_DOWN; sr_a = CW'(sr + 1'b1);
        end
      end
      SP_DOWN: begin
        if (sr < bb) begin
          sr_a = CW'(sr + 1'b1);
        end else begin
          br_a = CW'(br - 1'b1); dir_a = SP_LEFT; sc_a = CW'(sc - 1'b1);
        end
      end
      SP_LEFT: begin
        if (sc > bl) begin
          sc_a = CW'(sc - 1'b1);
        end else begin
          bb_a = CW'(bb - 1'b1); dir_a = SP_UP; sr_a = CW'(sr - 1'b1);
        end
      end
      SP_UP: begin
        if (sr > bt) begin
          sr_a = CW'(sr - 1'b1);
        end else begin
          bl_a = CW'(bl + 1'b1); dir_a = SP_RIGHT; sc_a = CW'(sc + 1'b1);
        end
      end
      default: begin
        dir_a = SP_RIGHT;
      end
    endcase
  end

  always_comb begin
    zr_d = zr_q; zc_d = zc_q; sr_d = sr_q; sc_d = sc_q;
    bt_d = bt_q; bb_d = bb_q; bl_d = bl_q; br_d = br_q;
    dir_d = dir_q; cnt_d = cnt_q; done_d = done_q;
    if (ctrl_i.reload) begin
      zr_d = '0; zc_d = '0; sr_d = '0; sc_d = '0;
      bt_d = '0; bl_d = '0; bb_d = edge_i; br_d = edge_i;
      dir_d = SP_RIGHT; cnt_d = '0; done_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (adv) begin
        zr_d = zr_a; zc_d = zc_a; sr_d = sr_a; sc_d = sc_a;
        bt_d = bt_a; bb_d = bb_a; bl_d = bl_a; br_d = br_a;
        dir_d = dir_a; cnt_d = SW'(cnt + 1'b1);
      end else begin
        zr_d = zr; zc_d = zc; sr_d = sr; sc_d = sc;
        bt_d = bt; bb_d = bb; bl_d = bl; br_d = br;
        dir_d = dir; cnt_d = cnt;
      end
      done_d = done || is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zr_q <= '0; zc_q <= '0; sr_q <= '0; sc_q <= '0;
      bt_q <= '0; bl_q <= '0;
      bb_q <= CW'(side_edge(GRID_RESET, MAX_SIDE));
      br_q <= CW'(side_edge(GRID_RESET, MAX_SIDE));
      dir_q <= SP_RIGHT; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      zr_q <= zr_d; zc_q <= zc_d; sr_q <= sr_d; sc_q <= sc_d;
      bt_q <= bt_d; bb_q <= bb_d; bl_q <= bl_d; br_q <= br_d;
      dir_q <= dir_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

/* sv/zigzag_to_spiral_address_gen_top.sv */
// Top level of the zigzag-to-spiral address generator: config register,
// handshakes and result register. Depends on zz2s_pkg and zz2s_scan.
//
//   channel | direction | handshake               | payload
//   cfg     | in        | cfg_we_i                | cfg_wdata_i (grid_size)
//   in      | in        | in_valid_i / in_stall_o | restart_i
//   out     | out       | out_valid_o/out_stall_i | src/dst row/col, last_o
//
// One transaction per cycle while not stalled; result comes the cycle after.
// Input is stalled only while a result is held and out_stall_i is high.
// Reset loads grid_size 8 and the start of a scan; a config write restarts it.
`default_nettype none

module zigzag_to_spiral_address_gen_top
  import zz2s_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [GS_W-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            restart_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [CW-1:0]   src_row_o,
  output logic      [CW-1:0]   src_col_o,
  output logic      [CW-1:0]   dst_row_o,
  output logic      [CW-1:0]   dst_col_o,
  output logic                 last_o
);

  localparam int PW       = 2 * (CW + 1);
  localparam int RST_EDGE = int'(side_edge(GRID_RESET, MAX_SIDE));
  localparam int RST_LAST = (RST_EDGE + 1) * (RST_EDGE + 1) - 1;

  logic [CW-1:0] edge_q, edge_d, new_edge, edge_use;
  logic [SW-1:0] last_idx_q, last_idx_d;
  logic [CW:0]   new_n;
  logic [PW-1:0] new_sq;
  logic          in_acc;
  scan_ctrl_t    ctrl;
  logic [CW-1:0] s_row, s_col, d_row, d_col;
  logic          s_last;
  logic          ov_q, ov_d;
  logic [CW-1:0] sr_q, sc_q, dr_q, dc_q;
  logic          last_q;

  assign new_edge = CW'(side_edge(cfg_wdata_i, MAX_SIDE));
  assign new_n    = {1'b0, new_edge} + (CW+1)'(1);
  assign new_sq   = PW'(new_n) * PW'(new_n);

  always_comb begin
    edge_d     = edge_q;
    last_idx_d = last_idx_q;
    if (cfg_we_i) begin
      edge_d     = new_edge;
      last_idx_d = SW'(new_sq - PW'(1));
    end
  end

  assign edge_use = cfg_we_i ? new_edge : edge_q;

  assign in_stall_o   = ov_q && out_stall_i;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign ctrl.step    = in_acc;
  assign ctrl.restart = restart_i;
  assign ctrl.reload  = cfg_we_i;

  zz2s_scan #(
    .MAX_SIDE (MAX_SIDE),
    .CW       (CW),
    .SW       (SW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .edge_i     (edge_use),
    .last_idx_i (last_idx_q),
    .src_row_o  (s_row),
    .src_col_o  (s_col),
    .dst_row_o  (d_row),
    .dst_col_o  (d_col),
    .last_o     (s_last)
  );

  assign ov_d = in_acc || (ov_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q     <= CW'(RST_EDGE);
      last_idx_q <= SW'(RST_LAST);
      ov_q       <= 1'b0;
    end else begin
      edge_q     <= edge_d;
      last_idx_q <= last_idx_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sr_q   <= s_row;
      sc_q   <= s_col;
      dr_q   <= d_row;
      dc_q   <= d_col;
      last_q <= s_last;
    end
  end

  assign out_valid_o = ov_q;
  assign src_row_o   = sr_q;
  assign src_col_o   = sc_q;
  assign dst_row_o   = dr_q;
  assign dst_col_o   = dc_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* sv/zz2s_checker.sv */
// Port-level checks for zigzag_to_spiral_address_gen_top, attached by bind.
// Depends on zz2s_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module zz2s_checker
  import zz2s_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DF,
  localparam int CW = $clog2(MAX_SIDE)
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire logic [CW-1:0] src_row_o,
  input wire logic [CW-1:0] src_col_o,
  input wire logic [CW-1:0] dst_row_o,
  input wire logic [CW-1:0] dst_col_o,
  input wire logic          last_o
);

  logic          in_acc, out_acc;
  logic [4*CW:0] out_bus;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign out_bus = {src_row_o, src_col_o, dst_row_o, dst_col_o, last_o};

  `ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o)
  `ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_acc, out_valid_o)
  `ASSERT_NEXT(a_drain_empties, clk_i, rst_ni, out_acc && !in_acc, !out_valid_o)
  `ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_bus))

endmodule

bind zigzag_to_spiral_address_gen_top zz2s_checker #(
  .MAX_SIDE (MAX_SIDE)
) u_zz2s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .src_row_o   (src_row_o),
  .src_col_o   (src_col_o),
  .dst_row_o   (dst_row_o),
  .dst_col_o   (dst_col_o),
  .last_o      (last_o)
);

`default_nettype wire
